[design/nsfr_pkg.sv]
// ============================================================================
// nsfr_pkg
// Shared types and constants for the NMEA sentence frame receiver.
// ============================================================================
package nsfr_pkg;

    typedef enum logic [1:0] {
        MODE_RX   = 2'd0,
        MODE_READ = 2'd1,
        MODE_ACK  = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        PH_WAIT  = 3'b001,
        PH_CHECK = 3'b010,
        PH_RECV  = 3'b100
    } phase_t;

    localparam logic [7:0]  CHAR_DOLLAR = 8'h24;
    localparam logic [7:0]  CHAR_CR     = 8'h0D;
    localparam logic [7:0]  CHAR_LF     = 8'h0A;
    localparam logic [2:0]  HEADER_LEN  = 3'd6;

    localparam int          SID_W          = 40;
    localparam logic [39:0] SENTENCE_RESET = 40'h474E524D43;

    localparam int          APB_DATA_W = 64;
    localparam int          APB_ADDR_W = 4;
    // register index is the 8-byte word address
    localparam logic        REG_SENTENCE_ID = 1'b0;

endpackage

[design/nsfr_in_if.sv]
// ============================================================================
// nsfr_in_if
// Input channel: valid/ready handshake with mode, rx_byte and read_index.
// ============================================================================
interface nsfr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic [6:0] read_index;

    modport source (output valid, output mode, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input mode, input rx_byte, input read_index,
                    output ready);
endinterface

[design/nsfr_out_if.sv]
// ============================================================================
// nsfr_out_if
// Result channel: valid/ready handshake with read data and frame status.
// ============================================================================
interface nsfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       frame_ready;
    logic [6:0] frame_length;
    logic       frame_done;
    logic       overflow;

    modport source (output valid, output read_data, output frame_ready,
                    output frame_length, output frame_done, output overflow,
                    input ready);
    modport sink   (input valid, input read_data, input frame_ready,
                    input frame_length, input frame_done, input overflow,
                    output ready);
endinterface

[design/nmea_sentence_frame_receiver_unit.sv]
// ============================================================================
// nmea_sentence_frame_receiver_unit
// NMEA sentence framer with a single-port frame buffer and APB config port.
// ============================================================================
// Accepts one transaction per clock and returns one result per transaction,
// valid in the cycle after acceptance; that register stage is the registered
// read port of the frame buffer. Input is held off only while a result waits unaccepted.
// Mode 0 feeds a received byte: '$' followed by the five configured id
// characters starts a frame, bytes are stored up to CR LF, then frame_ready
// is set and frame_length holds the size without CR LF. A frame that would
// fill the buffer is dropped and flagged by overflow. Mode 1 reads a stored
// byte, mode 2 clears frame_ready. The sentence id (reset "GNRMC") is at
// APB address 0, 64-bit data, low 40 bits used.
module nmea_sentence_frame_receiver_unit #(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    nsfr_in_if.sink                         in_ch,
    nsfr_out_if.source                      out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nsfr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [nsfr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [nsfr_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import nsfr_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int IW = (AW > 7) ? AW : 7;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [SID_W-1:0] sentence_id_reg;
    logic             cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[APB_ADDR_W-1] == REG_SENTENCE_ID);
    assign prdata  = cfg_sel ? APB_DATA_W'(sentence_id_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sentence_id_reg <= SENTENCE_RESET;
        end
        else if (psel && penable && pwrite && pready && cfg_sel)
        begin
            sentence_id_reg <= pwdata[SID_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    phase_t       phase_reg, phase_next;
    logic [2:0]   header_count_reg, header_count_next;
    logic [AW-1:0] fill_length_reg, fill_length_next;
    logic [7:0]   previous_byte_reg, previous_byte_next;
    logic         ready_flag_reg, ready_flag_next;
    logic [AW-1:0] completed_length_reg, completed_length_next;

    logic         out_valid_reg;
    logic         done_reg, done_next;
    logic         ovf_reg, ovf_next;
    logic         rd_sel_reg, rd_sel_next;

    logic         accept;
    logic         mem_we;
    logic [AW-1:0] mem_waddr;
    logic         mem_re;
    logic [AW-1:0] mem_raddr;
    logic [IW-1:0] idx_ext;
    logic         idx_in_range;
    logic [7:0]   expected;
    logic [7:0]   b;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign b           = in_ch.rx_byte;

    assign idx_ext      = IW'(in_ch.read_index);
    // one extra bit so that a depth equal to 2**IW still compares correctly
    assign idx_in_range = ({1'b0, idx_ext} < (IW+1)'(BUFFER_DEPTH));
    assign mem_raddr    = idx_ext[AW-1:0];
    assign mem_re       = accept && (mode_t'(in_ch.mode) == MODE_READ) && idx_in_range;

    always_comb
    begin
        case (header_count_reg)
            3'd1:    expected = sentence_id_reg[39:32];
            3'd2:    expected = sentence_id_reg[31:24];
            3'd3:    expected = sentence_id_reg[23:16];
            3'd4:    expected = sentence_id_reg[15:8];
            3'd5:    expected = sentence_id_reg[7:0];
            default: expected = 8'h00;
        endcase
    end

    always_comb
    begin
        phase_next            = phase_reg;
        header_count_next     = header_count_reg;
        fill_length_next      = fill_length_reg;
        previous_byte_next    = previous_byte_reg;
        ready_flag_next       = ready_flag_reg;
        completed_length_next = completed_length_reg;
        done_next             = 1'b0;
        ovf_next              = 1'b0;
        rd_sel_next           = 1'b0;
        mem_we                = 1'b0;
        mem_waddr             = '0;

        case (mode_t'(in_ch.mode))
            MODE_RX:
            begin
                case (phase_reg)
                    PH_WAIT:
                    begin
                        if (b == CHAR_DOLLAR)
                        begin
                            mem_we            = 1'b1;
                            mem_waddr         = '0;
                            header_count_next = 3'd1;
                            phase_next        = PH_CHECK;
                        end
                    end
                    PH_CHECK:
                    begin
                        // header_count stays in 1..5 here, so expected is valid
                        if (b == expected && header_count_reg != 3'd0)
                        begin
                            mem_we            = 1'b1;
                            mem_waddr         = AW'(header_count_reg);
                            header_count_next = header_count_reg + 3'd1;
                            if (header_count_next == HEADER_LEN)
                            begin
                                phase_next       = PH_RECV;
                                fill_length_next = AW'(HEADER_LEN);
                            end
                        end
                        else
                        begin
                            phase_next       = PH_WAIT;
                            fill_length_next = '0;
                        end
                    end
                    PH_RECV:
                    begin
                        if (fill_length_reg < AW'(BUFFER_DEPTH - 1))
                        begin
                            mem_we             = 1'b1;
                            mem_waddr          = fill_length_reg;
                            fill_length_next   = fill_length_reg + 1'b1;
                            previous_byte_next = b;
                            if (previous_byte_reg == CHAR_CR && b == CHAR_LF)
                            begin
                                ready_flag_next       = 1'b1;
                                // stored count minus CR LF
                                completed_length_next = fill_length_reg - 1'b1;
                                fill_length_next      = '0;
                                phase_next            = PH_WAIT;
                                done_next             = 1'b1;
                            end
                        end
                        else
                        begin
                            fill_length_next   = '0;
                            previous_byte_next = 8'h00;
                            phase_next         = PH_WAIT;
                            ovf_next           = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_WAIT;
                    end
                endcase
            end
            MODE_READ:
            begin
                rd_sel_next = idx_in_range;
            end
            MODE_ACK:
            begin
                ready_flag_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_WAIT;
            header_count_reg     <= 3'd0;
            fill_length_reg      <= '0;
            previous_byte_reg    <= 8'h00;
            ready_flag_reg       <= 1'b0;
            completed_length_reg <= '0;
            out_valid_reg        <= 1'b0;
            done_reg             <= 1'b0;
            ovf_reg              <= 1'b0;
            rd_sel_reg           <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg            <= phase_next;
                header_count_reg     <= header_count_next;
                fill_length_reg      <= fill_length_next;
                previous_byte_reg    <= previous_byte_next;
                ready_flag_reg       <= ready_flag_next;
                completed_length_reg <= completed_length_next;
                done_reg             <= done_next;
                ovf_reg              <= ovf_next;
                rd_sel_reg           <= rd_sel_next;
                out_valid_reg        <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Frame buffer: one write or one read per cycle, registered read data
    // ------------------------------------------------------------------
    logic [7:0] frame_mem [BUFFER_DEPTH];
    logic [7:0] mem_q_reg;

    always_ff @(posedge clk)
    begin
        if (accept && mem_we)
        begin
            frame_mem[mem_waddr] <= b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_q_reg <= frame_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Result channel; status registers hold while the result is stalled
    // ------------------------------------------------------------------
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.read_data    = rd_sel_reg ? mem_q_reg : 8'h00;
    assign out_ch.frame_ready  = ready_flag_reg;
    assign out_ch.frame_length = 7'(completed_length_reg);
    assign out_ch.frame_done   = done_reg;
    assign out_ch.overflow     = ovf_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |-> !in_ch.ready)
        else $error("input accepted while result stalled");

    a_done_ovf_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(done_reg && ovf_reg))
        else $error("frame_done and overflow both set");

    a_done_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> ready_flag_reg)
        else $error("frame completed without ready flag");

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_length_reg <= AW'(BUFFER_DEPTH - 1))
        else $error("fill length beyond buffer");

    a_read_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |=> out_valid_reg && rd_sel_reg)
        else $error("buffer read without matching result");

endmodule

[tb/tb_top.sv]
// ============================================================================
// tb_top
// Self-checking testbench for nmea_sentence_frame_receiver_unit.
// ============================================================================
// A queue of pending transactions is filled per sentence id setting. It starts
// with directed sentences and continues with random sentences, broken headers,
// reads, acknowledges and noise. A clocked driver sends the queue in bursts. A
// clocked monitor predicts the status of every accepted transaction and checks
// each returned result field by field. The id register is rewritten over APB
// between phases, while the block is idle.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;
    import nsfr_pkg::*;

    localparam int BUF_DEPTH = 128;
    // frames never reach the last entry, so reads stop one short of it
    localparam int READ_TOP = BUF_DEPTH - 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [APB_ADDR_W-1:0] SID_ADDR = APB_ADDR_W'(8 * REG_SENTENCE_ID);

    typedef struct {
        mode_t      mode;
        logic [7:0] rx_byte;
        logic [6:0] read_index;
        bit         drain_first;
    } rx_txn_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       frame_ready;
        logic [6:0] frame_length;
        logic       frame_done;
        logic       overflow;
    } frame_status_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    nsfr_in_if  rx_if ();
    nsfr_out_if st_if ();

    nmea_sentence_frame_receiver_unit #(
        .BUFFER_DEPTH(BUF_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(rx_if),
        .out_ch(st_if),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #4 clk = ~clk;

    rx_txn_t       pending_items[$];
    frame_status_t expected_status[$];
    int queued_count = 0;
    int accepted_count = 0;
    int error_count = 0;
    int cycle_count = 0;
    bit in_taken = 1'b0;

    // predictor state
    logic [39:0] sid_cfg = SENTENCE_RESET;
    phase_t      rx_phase = PH_WAIT;
    logic [2:0]  hdr_count = '0;
    logic [6:0]  fill_len = '0;
    logic [7:0]  last_byte = '0;
    logic        flag_ready = 1'b0;
    logic [6:0]  done_len = '0;
    bit   [7:0]  frame_mem [BUF_DEPTH];

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 100)
            $display("[%0t] ERROR %s", $time, what);
    endtask

    function automatic frame_status_t predict_status(mode_t m, logic [7:0] b,
                                                     logic [6:0] idx);
        frame_status_t st;
        st = '0;
        case (m)
            MODE_RX:
            begin
                case (rx_phase)
                    PH_WAIT:
                    begin
                        if (b == CHAR_DOLLAR)
                        begin
                            frame_mem[0] = b;
                            hdr_count = 3'd1;
                            rx_phase = PH_CHECK;
                        end
                    end
                    PH_CHECK:
                    begin
                        if (hdr_count >= 1 && hdr_count <= 5 &&
                            b == sid_cfg[8 * (5 - int'(hdr_count)) +: 8])
                        begin
                            frame_mem[hdr_count] = b;
                            hdr_count++;
                            if (hdr_count == HEADER_LEN)
                            begin
                                rx_phase = PH_RECV;
                                fill_len = 7'(HEADER_LEN);
                            end
                        end
                        else
                        begin
                            // the mismatching byte is dropped, '$' included
                            rx_phase = PH_WAIT;
                            fill_len = '0;
                        end
                    end
                    PH_RECV:
                    begin
                        if (fill_len < BUF_DEPTH - 1)
                        begin
                            frame_mem[fill_len] = b;
                            fill_len++;
                            if (last_byte == CHAR_CR && b == CHAR_LF)
                            begin
                                flag_ready = 1'b1;
                                done_len = fill_len - 7'd2;
                                fill_len = '0;
                                rx_phase = PH_WAIT;
                                st.frame_done = 1'b1;
                            end
                            last_byte = b;
                        end
                        else
                        begin
                            fill_len = '0;
                            last_byte = '0;
                            rx_phase = PH_WAIT;
                            st.overflow = 1'b1;
                        end
                    end
                    default: rx_phase = PH_WAIT;
                endcase
            end
            MODE_READ: st.read_data = frame_mem[idx];
            MODE_ACK:  flag_ready = 1'b0;
            default: ;
        endcase
        st.frame_ready = flag_ready;
        st.frame_length = done_len;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    task automatic push_item(input mode_t m, input logic [7:0] b, input logic [6:0] idx);
        rx_txn_t t;
        t.mode = m;
        t.rx_byte = b;
        t.read_index = idx;
        t.drain_first = 1'b0;
        pending_items.push_back(t);
        queued_count++;
    endtask

    task automatic push_rx(input logic [7:0] b);
        push_item(MODE_RX, b, 7'($urandom_range(0, READ_TOP)));
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_rx(s[i]);
    endtask

    task automatic push_side();
        case ($urandom_range(0, 3))
            0, 1: push_item(MODE_READ, 8'($urandom), 7'($urandom_range(0, READ_TOP)));
            2:    push_item(MODE_ACK, 8'($urandom), 7'($urandom_range(0, READ_TOP)));
            default: push_item(MODE_NOP, 8'($urandom), 7'($urandom_range(0, READ_TOP)));
        endcase
    endtask

    // body bytes avoid LF so that only the closing CR LF ends the sentence
    task automatic push_frame(input int body_len, input bit terminate, input bit mix);
        logic [7:0] b;
        push_rx(CHAR_DOLLAR);
        for (int i = 0; i < 5; i++)
            push_rx(sid_cfg[8 * (4 - i) +: 8]);
        for (int i = 0; i < body_len; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == CHAR_LF)
                b = 8'h0B;
            push_rx(b);
            if (mix && $urandom_range(0, 9) == 0)
                push_side();
        end
        if (terminate)
        begin
            push_rx(CHAR_CR);
            push_rx(CHAR_LF);
        end
    endtask

    task automatic run_random(input int count);
        int stop;
        int r;
        int k;
        stop = queued_count + count;
        while (queued_count < stop)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                k = $urandom_range(0, 19);
                if (k < 17)
                    push_frame($urandom_range(0, 20), 1'b1, 1'b1);
                else if (k < 19)
                    push_frame($urandom_range(0, 1) ? 119 : $urandom_range(21, 118),
                               1'b1, 1'b1);
                else
                    push_frame($urandom_range(122, 130), 1'b0, 1'b1);
            end
            else if (r < 70)
            begin
                // header that breaks after k good id characters
                k = $urandom_range(0, 4);
                push_rx(CHAR_DOLLAR);
                for (int i = 0; i < k; i++)
                    push_rx(sid_cfg[8 * (4 - i) +: 8]);
                push_rx(sid_cfg[8 * (4 - k) +: 8] ^ 8'($urandom_range(1, 255)));
                repeat ($urandom_range(0, 3))
                    push_rx(8'($urandom));
            end
            else if (r < 96)
                push_side();
            else
                repeat ($urandom_range(1, 5))
                    push_rx(8'($urandom));
            if ($urandom_range(0, 49) == 0)
                pending_items[$].drain_first = 1'b1;
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (accepted_count != queued_count || expected_status.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_set_sentence_id(input logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SID_ADDR;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        sid_cfg = value[39:0];
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[39:0] !== sid_cfg)
            report_mismatch($sformatf("sentence_id read back %h, want %h",
                                      prdata[39:0], sid_cfg));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of transactions with random gaps
    // ------------------------------------------------------------------
    int burst_left = 4;
    int gap_left = 0;

    always @(negedge clk)
    begin
        rx_txn_t nxt;
        if (!(rx_if.valid && !in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                rx_if.valid <= 1'b0;
            end
            else if (pending_items.size() > 0 &&
                     !(pending_items[0].drain_first && expected_status.size() != 0))
            begin
                nxt = pending_items.pop_front();
                rx_if.valid <= 1'b1;
                rx_if.mode <= nxt.mode;
                rx_if.rx_byte <= nxt.rx_byte;
                rx_if.read_index <= nxt.read_index;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                rx_if.valid <= 1'b0;
        end
    end

    // result side stalls on a random 8-bit pattern, redrawn when stall_left runs out
    int stall_left = 0;
    logic [7:0] stall_pattern = 8'hFF;

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_left = 32;
            stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        end
        stall_left--;
        st_if.ready <= stall_pattern[stall_left % 8];
    end

    // ------------------------------------------------------------------
    // monitor: predict on input accept, check on result accept
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        frame_status_t want;
        in_taken = rx_if.valid && rx_if.ready;
        if (in_taken)
        begin
            expected_status.push_back(predict_status(mode_t'(rx_if.mode), rx_if.rx_byte,
                                                     rx_if.read_index));
            accepted_count++;
        end
        if (st_if.valid && st_if.ready)
        begin
            if (expected_status.size() == 0)
                report_mismatch("result with no transaction pending");
            else
            begin
                want = expected_status.pop_front();
                if (st_if.read_data !== want.read_data)
                    report_mismatch($sformatf("read_data %h, want %h",
                                              st_if.read_data, want.read_data));
                if (st_if.frame_ready !== want.frame_ready)
                    report_mismatch($sformatf("frame_ready %b, want %b",
                                              st_if.frame_ready, want.frame_ready));
                if (st_if.frame_length !== want.frame_length)
                    report_mismatch($sformatf("frame_length %0d, want %0d",
                                              st_if.frame_length, want.frame_length));
                if (st_if.frame_done !== want.frame_done)
                    report_mismatch($sformatf("frame_done %b, want %b",
                                              st_if.frame_done, want.frame_done));
                if (st_if.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %b, want %b",
                                              st_if.overflow, want.overflow));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL nmea_sentence_frame_receiver_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [63:0] id_settings [5];
        id_settings[0] = 64'h0000_00FF_FFFF_FFFF;
        id_settings[1] = 64'h0;
        id_settings[2] = 64'h0000_0024_2424_2424;
        id_settings[3] = {24'h0, 8'($urandom), 32'($urandom)};
        // reset value back, with junk above the 40 used bits
        id_settings[4] = {24'hA5A5A5, SENTENCE_RESET};

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rx_if.valid = 1'b0;
        rx_if.mode = MODE_NOP;
        rx_if.rx_byte = '0;
        rx_if.read_index = '0;
        st_if.ready = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // full store first: writes every entry a read may later touch
        push_frame(122, 1'b0, 1'b0);
        push_item(MODE_READ, 8'h00, 7'd0);
        pending_items[$].drain_first = 1'b1;
        push_item(MODE_READ, 8'hFF, 7'(READ_TOP));
        push_item(MODE_NOP, 8'hFF, 7'h55);
        push_item(MODE_ACK, 8'h00, 7'h2A);
        // '$' as a header mismatch is dropped, so the id that follows is ignored
        push_text("$GN$GNRMC");
        // body opening with LF, stray '$' and a CR not followed by LF
        push_text("$GNRMC");
        push_rx(CHAR_LF);
        push_rx(CHAR_DOLLAR);
        push_rx(CHAR_CR);
        push_rx(8'h41);
        push_rx(CHAR_CR);
        push_rx(CHAR_LF);
        // second sentence while the first is still unacknowledged
        push_text("$GNRMC");
        push_rx(8'hFF);
        push_rx(8'h00);
        push_rx(CHAR_CR);
        push_rx(CHAR_LF);
        push_item(MODE_READ, 8'h00, 7'd7);
        push_item(MODE_ACK, 8'h00, 7'd0);
        push_item(MODE_ACK, 8'hFF, 7'd0);
        run_random(140);
        wait_idle();

        foreach (id_settings[i])
        begin
            apb_set_sentence_id(id_settings[i]);
            run_random(140);
            wait_idle();
        end

        if (error_count == 0)
            $display("PASS nmea_sentence_frame_receiver_unit");
        else
            $display("FAIL nmea_sentence_frame_receiver_unit");
        $finish;
    end

endmodule
